>>> rtl/rpv_pkg.sv
// ----------------------------------------------------------------------------
// rpv_pkg: shared definitions for the rectangular/polar vector unit
// Command codes, fixed-point widths, CORDIC constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rpv_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int FRAC_BITS         = 16;
	localparam int GUARD_BITS        = 16;
	localparam int DW                = 52;
	localparam int ZW                = 34;

	localparam logic [31:0] KINV_Q32     = 32'd2608131496;
	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [31:0] DIV45_RECIP  = 32'd3054198966;
	localparam int          DIV45_SHIFT  = 37;

	localparam logic [2:0] CMD_RECT  = 3'd0;
	localparam logic [2:0] CMD_POLAR = 3'd1;
	localparam logic [2:0] CMD_ADD   = 3'd2;
	localparam logic [2:0] CMD_SUB   = 3'd3;
	localparam logic [2:0] CMD_NEG   = 3'd4;
	localparam logic [2:0] CMD_SCALE = 3'd5;

	typedef logic signed [DW-1:0] cdata_t;
	typedef logic signed [ZW-1:0] cangle_t;

	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rpv_cordic_cell.sv
// ----------------------------------------------------------------------------
// rpv_cordic_cell: one micro-rotation of the CORDIC chain
// Rotates the vector by plus or minus the stage angle, steered by the angle
// sign in rotation mode or by the y sign in vectoring mode, and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_cordic_cell
	import rpv_pkg::*;
#(
	parameter int STAGE     = 0,
	parameter bit VECTORING = 1'b0,
	parameter int SIDE_W    = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_i,
	input  wire cdata_t            x_i,
	input  wire cdata_t            y_i,
	input  wire cangle_t           z_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   valid_o,
	output cdata_t                 x_o,
	output cdata_t                 y_o,
	output cangle_t                z_o,
	output logic [SIDE_W-1:0]      side_o
);

	localparam cangle_t STEP = cangle_t'(atan_turn(STAGE));

	logic              valid_q;
	cdata_t            x_q;
	cdata_t            y_q;
	cangle_t           z_q;
	logic [SIDE_W-1:0] side_q;
	logic              up;
	cdata_t            xs;
	cdata_t            ys;

	assign up = VECTORING ? y_i[DW-1] : !z_i[ZW-1];
	assign xs = x_i >>> STAGE;
	assign ys = y_i >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (up) begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - STEP;
			end else begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + STEP;
			end
		end
	end

	assign valid_o = valid_q;
	assign x_o     = x_q;
	assign y_o     = y_q;
	assign z_o     = z_q;
	assign side_o  = side_q;

endmodule

`default_nettype wire

>>> rtl/rect_polar_vector_unit_top.sv
// ----------------------------------------------------------------------------
// rect_polar_vector_unit_top: two-dimensional Q16.16 vector unit
// Loads, adds, subtracts, negates or scales a vector and reports its x, y,
// magnitude and direction through two chains of CORDIC cells.
//
// The input channel (in_valid, in_ready) carries one command beat with its
// operands; the output channel (out_valid, out_ready) carries one result beat
// per command, in order. A polar load converts magnitude and degrees through
// the rotation chain; every result then passes the vectoring chain, which
// gives magnitude and angle in radians. Invalid commands return the zero
// vector with bad_command set.
// The path from the accepting edge to out_valid runs through two input stages,
// the rotation chain, three stages of rounding and gain compensation, the
// vectoring chain, the angle scaling stage and the output register. One beat
// is accepted every cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and in_ready falls in
// the same cycle; nothing is lost. Reset empties the pipeline; no beat is
// pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_polar_vector_unit_top
	import rpv_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         command,
	input  wire logic signed [31:0] first_a,
	input  wire logic signed [31:0] first_b,
	input  wire logic signed [31:0] second_x,
	input  wire logic signed [31:0] second_y,
	input  wire logic signed [31:0] factor,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_x,
	output logic signed [31:0]      result_y,
	output logic [30:0]             magnitude,
	output logic signed [18:0]      angle_radians,
	output logic                    bad_command
);

	localparam int SIDE_W = 66;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: products and operand capture.
	logic                v_s1;
	logic [2:0]          cmd_s1;
	logic signed [31:0]  a_s1, b_s1, sx_s1, sy_s1;
	logic signed [63:0]  fa_s1, fb_s1;
	logic signed [64:0]  pa_s1;
	logic [63:0]         degp_s1;
	logic [31:0]         babs_s1;
	logic                bneg_s1;
	logic [31:0]         b_abs;

	assign b_abs = first_b[31] ? 32'(-first_b) : first_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= command;
			a_s1    <= first_a;
			b_s1    <= first_b;
			sx_s1   <= second_x;
			sy_s1   <= second_y;
			fa_s1   <= 64'(factor) * 64'(first_a);
			fb_s1   <= 64'(factor) * 64'(first_b);
			pa_s1   <= 65'(first_a) * $signed({33'd0, KINV_Q32});
			degp_s1 <= 64'(b_abs) * 64'(DIV45_RECIP);
			babs_s1 <= b_abs;
			bneg_s1 <= first_b[31];
		end
	end

	// Stage 2: direct results, degrees to binary angle, rotation start.
	logic [26:0]         qe;
	logic [32:0]         rem_w;
	logic                fix;
	logic [26:0]         qd;
	logic [5:0]          rr;
	logic [39:0]         kt;
	logic [39:0]         kneg;
	logic [31:0]         t32;
	logic [31:0]         tq;
	logic                flip;
	logic [31:0]         a_rot;
	logic signed [65:0]  pr;
	cdata_t              rx0;
	logic signed [31:0]  xd, yd;
	logic                bad_w;

	assign qe    = degp_s1[DIV45_SHIFT+26:DIV45_SHIFT];
	assign rem_w = {1'b0, babs_s1} - 33'(qe) * 33'd45;
	assign fix   = rem_w >= 33'd45;
	assign qd    = fix ? qe + 27'd1 : qe;
	assign rr    = fix ? 6'(rem_w - 33'd45) : rem_w[5:0];
	assign kt    = {qd, 13'd0} + 40'(rr) * 40'd182
		+ ((rr >= 6'd34) ? 40'd2 : (rr >= 6'd12) ? 40'd1 : 40'd0);
	assign kneg  = 40'd0 - kt;
	assign t32   = bneg_s1 ? kneg[31:0] : kt[31:0];
	assign tq    = t32 + 32'h40000000;
	assign flip  = tq[31];
	assign a_rot = flip ? t32 + 32'h80000000 : t32;
	assign pr    = 66'(pa_s1) + 66'sd32768;
	assign rx0   = DW'($signed(pr[65:16]));

	always_comb begin
		xd    = '0;
		yd    = '0;
		bad_w = 1'b0;
		case (cmd_s1)
			CMD_RECT: begin
				xd = a_s1;
				yd = b_s1;
			end
			CMD_POLAR: begin
				xd = '0;
				yd = '0;
			end
			CMD_ADD: begin
				xd = sat32(64'(a_s1) + 64'(sx_s1));
				yd = sat32(64'(b_s1) + 64'(sy_s1));
			end
			CMD_SUB: begin
				xd = sat32(64'(a_s1) - 64'(sx_s1));
				yd = sat32(64'(b_s1) - 64'(sy_s1));
			end
			CMD_NEG: begin
				xd = sat32(-64'(a_s1));
				yd = sat32(-64'(b_s1));
			end
			CMD_SCALE: begin
				xd = sat32((fa_s1 + 64'sd32768) >>> 16);
				yd = sat32((fb_s1 + 64'sd32768) >>> 16);
			end
			default: begin
				bad_w = 1'b1;
			end
		endcase
	end

	logic               v_s2;
	cdata_t             rx_s2;
	cangle_t            rz_s2;
	logic [SIDE_W-1:0]  rside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s2    <= flip ? -rx0 : rx0;
			rz_s2    <= ZW'($signed(a_rot));
			rside_s2 <= {xd, yd, cmd_s1 == CMD_POLAR, bad_w};
		end
	end

	// Rotation chain.
	logic              rv [0:CORDIC_STAGES];
	cdata_t            rxc [0:CORDIC_STAGES];
	cdata_t            ryc [0:CORDIC_STAGES];
	cangle_t           rzc [0:CORDIC_STAGES];
	logic [SIDE_W-1:0] rsc [0:CORDIC_STAGES];

	assign rv[0]  = v_s2;
	assign rxc[0] = rx_s2;
	assign ryc[0] = '0;
	assign rzc[0] = rz_s2;
	assign rsc[0] = rside_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		rpv_cordic_cell #(
			.STAGE(i),
			.VECTORING(1'b0),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_i(rv[i]),
			.x_i(rxc[i]),
			.y_i(ryc[i]),
			.z_i(rzc[i]),
			.side_i(rsc[i]),
			.valid_o(rv[i+1]),
			.x_o(rxc[i+1]),
			.y_o(ryc[i+1]),
			.z_o(rzc[i+1]),
			.side_o(rsc[i+1])
		);
	end

	// Stage 3: rounding of the rotated vector.
	cdata_t             rxr, ryr;
	logic [SIDE_W-1:0]  rend;
	logic               v_s3, bad_s3;
	logic signed [31:0] x_s3, y_s3;

	assign rend = rsc[CORDIC_STAGES];
	assign rxr  = (rxc[CORDIC_STAGES] + cdata_t'(32768)) >>> GUARD_BITS;
	assign ryr  = (ryc[CORDIC_STAGES] + cdata_t'(32768)) >>> GUARD_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= rv[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= rend[1] ? sat32(64'(rxr)) : $signed(rend[65:34]);
			y_s3   <= rend[1] ? sat32(64'(ryr)) : $signed(rend[33:2]);
			bad_s3 <= rend[0];
		end
	end

	// Stage 4: gain compensation products.
	logic               v_s4, bad_s4, zero_s4;
	logic signed [31:0] x_s4, y_s4;
	logic signed [64:0] px_s4, py_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			bad_s4  <= bad_s3;
			zero_s4 <= (x_s3 == 32'sd0) && (y_s3 == 32'sd0);
			px_s4   <= 65'(x_s3) * $signed({33'd0, KINV_Q32});
			py_s4   <= 65'(y_s3) * $signed({33'd0, KINV_Q32});
		end
	end

	// Stage 5: vectoring start, folded into the right half plane.
	logic signed [65:0] pxr, pyr;
	cdata_t             vx0, vy0;
	logic               v_s5;
	cdata_t             vx_s5, vy_s5;
	cangle_t            vz_s5;
	logic [SIDE_W-1:0]  vside_s5;

	assign pxr = 66'(px_s4) + 66'sd32768;
	assign pyr = 66'(py_s4) + 66'sd32768;
	assign vx0 = DW'($signed(pxr[65:16]));
	assign vy0 = DW'($signed(pyr[65:16]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vside_s5 <= {x_s4, y_s4, bad_s4, zero_s4};
			if (x_s4[31]) begin
				vx_s5 <= -vx0;
				vy_s5 <= -vy0;
				vz_s5 <= y_s4[31] ? -cangle_t'(64'sd2147483648)
					: cangle_t'(64'sd2147483648);
			end else begin
				vx_s5 <= vx0;
				vy_s5 <= vy0;
				vz_s5 <= '0;
			end
		end
	end

	// Vectoring chain.
	logic              vv [0:CORDIC_STAGES];
	cdata_t            vxc [0:CORDIC_STAGES];
	cdata_t            vyc [0:CORDIC_STAGES];
	cangle_t           vzc [0:CORDIC_STAGES];
	logic [SIDE_W-1:0] vsc [0:CORDIC_STAGES];

	assign vv[0]  = v_s5;
	assign vxc[0] = vx_s5;
	assign vyc[0] = vy_s5;
	assign vzc[0] = vz_s5;
	assign vsc[0] = vside_s5;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		rpv_cordic_cell #(
			.STAGE(i),
			.VECTORING(1'b1),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_i(vv[i]),
			.x_i(vxc[i]),
			.y_i(vyc[i]),
			.z_i(vzc[i]),
			.side_i(vsc[i]),
			.valid_o(vv[i+1]),
			.x_o(vxc[i+1]),
			.y_o(vyc[i+1]),
			.z_o(vzc[i+1]),
			.side_o(vsc[i+1])
		);
	end

	// Stage 6: magnitude rounding and angle scaling product.
	cdata_t             mr;
	logic [30:0]        mclamp;
	cangle_t            zend;
	logic signed [32:0] zc;
	logic               v_s6;
	logic [SIDE_W-1:0]  vend_s6;
	logic [30:0]        mag_s6;
	logic signed [65:0] zp_s6;

	assign mr   = (vxc[CORDIC_STAGES] + cdata_t'(32768)) >>> GUARD_BITS;
	assign zend = vzc[CORDIC_STAGES];

	always_comb begin
		if (mr[DW-1]) begin
			mclamp = '0;
		end else if (mr > cdata_t'(64'sd2147483647)) begin
			mclamp = 31'h7FFFFFFF;
		end else begin
			mclamp = mr[30:0];
		end
		if (zend > cangle_t'(64'sd2147483648)) begin
			zc = 33'sh080000000;
		end else if (zend < -cangle_t'(64'sd2147483648)) begin
			zc = -33'sh080000000;
		end else begin
			zc = zend[32:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= vv[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vend_s6 <= vsc[CORDIC_STAGES];
			mag_s6  <= mclamp;
			zp_s6   <= 66'(zc) * $signed({34'd0, PI_Q30});
		end
	end

	// Output register.
	logic signed [65:0] zr;
	logic               none_w;
	logic               out_valid_q;
	logic signed [31:0] rx_q, ry_q;
	logic [30:0]        mag_q;
	logic signed [18:0] ang_q;
	logic               bad_q;

	assign zr     = (zp_s6 + 66'sd17592186044416) >>> (61 - FRAC_BITS);
	assign none_w = vend_s6[1] || vend_s6[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_q  <= $signed(vend_s6[65:34]);
			ry_q  <= $signed(vend_s6[33:2]);
			bad_q <= vend_s6[1];
			mag_q <= none_w ? 31'd0 : mag_s6;
			ang_q <= none_w ? 19'sd0 : zr[18:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign result_x      = rx_q;
	assign result_y      = ry_q;
	assign magnitude     = mag_q;
	assign angle_radians = ang_q;
	assign bad_command   = bad_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_command |-> result_x == 32'sd0 && result_y == 32'sd0
			&& magnitude == 31'd0 && angle_radians == 19'sd0)
		else $error("invalid command did not give the zero vector");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_x == 32'sd0 && result_y == 32'sd0
			|-> magnitude == 31'd0 && angle_radians == 19'sd0)
		else $error("zero vector has nonzero magnitude or angle");

	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_radians <= 19'sd205887 && angle_radians >= -19'sd205887)
		else $error("angle outside plus or minus pi");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for rect_polar_vector_unit_top
// Drives command beats with random gaps, back-pressures the result channel at
// random and predicts every result with a bit-exact CORDIC model of its own.
// A scoreboard class holds the predicted results in order and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import rpv_pkg::*;

	localparam int STAGES = 24;
	localparam int LATENCY = 2 * STAGES + 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic [30:0]        mag;
		logic signed [18:0] ang;
		logic               bad;
	} vec_result_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint atan_step(input int i);
		longint t[32] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
			'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
			'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
			'h00000001, 'h00000000};
		return t[i];
	endfunction

	function automatic longint gain_comp(input longint v);
		return rnd_shift(v * 64'sd2608131496, 32 - 16);
	endfunction

	function automatic void rotate_polar(input longint m, input logic [31:0] a,
			output longint ox, output longint oy);
		longint x, y, z, nx;
		logic [31:0] t;
		x = gain_comp(m);
		y = 0;
		t = a + 32'h40000000;
		if (t[31]) begin
			a = a + 32'h80000000;
			x = -x;
		end
		z = longint'(signed'(a));
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= atan_step(i);
			end else begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += atan_step(i);
			end
			x = nx;
		end
		ox = clamp32(rnd_shift(x, 16));
		oy = clamp32(rnd_shift(y, 16));
	endfunction

	function automatic void vector_polar(input longint x, input longint y,
			output longint om, output longint oa);
		longint bx, by, z, nx, m;
		if (x == 0 && y == 0) begin
			om = 0;
			oa = 0;
			return;
		end
		bx = gain_comp(x);
		by = gain_comp(y);
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
			bx = -bx;
			by = -by;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (by < 0) begin
				nx = bx - asr(by, i);
				by = by + asr(bx, i);
				z -= atan_step(i);
			end else begin
				nx = bx + asr(by, i);
				by = by - asr(bx, i);
				z += atan_step(i);
			end
			bx = nx;
		end
		m = rnd_shift(bx, 16);
		if (m < 0) m = 0;
		if (m > 64'sd2147483647) m = 64'sd2147483647;
		if (z > 64'sd2147483648) z = 64'sd2147483648;
		if (z < -64'sd2147483648) z = -64'sd2147483648;
		om = m;
		oa = rnd_shift(z * 64'sd3373259426, 61 - 16);
	endfunction

	function automatic vec_result_t predict_vector(input logic [2:0] cmd,
			input longint a, input longint b, input longint sx, input longint sy,
			input longint f);
		vec_result_t r;
		longint x, y, mg, an, n, q;
		logic bad;
		x = 0; y = 0; mg = 0; an = 0; bad = 0;
		case (cmd)
			CMD_RECT: begin x = a; y = b; end
			CMD_POLAR: begin
				n = b * 65536;
				q = (n >= 0) ? (n + 180) / 360 : -((180 - n) / 360);
				rotate_polar(a, q[31:0], x, y);
			end
			CMD_ADD: begin x = clamp32(a + sx); y = clamp32(b + sy); end
			CMD_SUB: begin x = clamp32(a - sx); y = clamp32(b - sy); end
			CMD_NEG: begin x = clamp32(-a); y = clamp32(-b); end
			CMD_SCALE: begin
				x = clamp32(rnd_shift(f * a, 16));
				y = clamp32(rnd_shift(f * b, 16));
			end
			default: bad = 1;
		endcase
		if (!bad) vector_polar(x, y, mg, an);
		r.rx = x[31:0];
		r.ry = y[31:0];
		r.mag = mg[30:0];
		r.ang = an[18:0];
		r.bad = bad;
		return r;
	endfunction

	class vector_scoreboard;
		vec_result_t pending[$];
		int checked = 0;

		function void note_command(input logic [2:0] cmd, input logic signed [31:0] a,
				input logic signed [31:0] b, input logic signed [31:0] sx,
				input logic signed [31:0] sy, input logic signed [31:0] f);
			pending.push_back(predict_vector(cmd, a, b, sx, sy, f));
		endfunction

		task check_result(input vec_result_t got);
			vec_result_t w;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			w = pending.pop_front();
			checked++;
			if (got.rx !== w.rx) report($sformatf("result_x %0d, want %0d", got.rx, w.rx));
			if (got.ry !== w.ry) report($sformatf("result_y %0d, want %0d", got.ry, w.ry));
			if (got.mag !== w.mag) report($sformatf("magnitude %0d, want %0d", got.mag, w.mag));
			if (got.ang !== w.ang) report($sformatf("angle %0d, want %0d", got.ang, w.ang));
			if (got.bad !== w.bad) report($sformatf("bad_command %0b, want %0b", got.bad, w.bad));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] command = '0;
	logic signed [31:0] first_a = '0, first_b = '0, second_x = '0, second_y = '0;
	logic signed [31:0] factor = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] result_x, result_y;
	logic [30:0] magnitude;
	logic signed [18:0] angle_radians;
	logic bad_command;

	vector_scoreboard board = new();
	int n_sent = 0;
	int idle_cycles = 0;
	bit stall_hold = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	rect_polar_vector_unit_top #(.CORDIC_STAGES(STAGES)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .first_a(first_a), .first_b(first_b),
		.second_x(second_x), .second_y(second_y), .factor(factor),
		.out_valid(out_valid), .out_ready(out_ready), .result_x(result_x),
		.result_y(result_y), .magnitude(magnitude), .angle_radians(angle_radians),
		.bad_command(bad_command)
	);

	task automatic send_beat(input logic [2:0] cmd, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] sx,
			input logic signed [31:0] sy, input logic signed [31:0] f);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		first_a <= a;
		first_b <= b;
		second_x <= sx;
		second_y <= sy;
		factor <= f;
		do @(posedge clk); while (!in_ready);
		board.note_command(cmd, a, b, sx, sy, f);
		n_sent++;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			4: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// Result side: random back-pressure, plus one long hold-off.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (stall_hold) begin
				out_ready <= 0;
				@(posedge clk);
			end else begin
				gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
				if (gap != 0) begin
					out_ready <= 0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1;
				do @(posedge clk); while (!out_valid);
				board.check_result('{result_x, result_y, magnitude, angle_radians,
					bad_command});
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (600) @(posedge clk);
		stall_hold = 1;
		repeat (300) @(posedge clk);
		stall_hold = 0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [2:0] c;
		logic signed [31:0] a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_beat(CMD_RECT, 0, 0, 0, 0, 0);
		send_beat(CMD_RECT, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
		send_beat(CMD_RECT, 32'sh80000000, 0, 0, 0, 0);
		send_beat(CMD_RECT, -32'sh10000, 0, 0, 0, 0);
		send_beat(CMD_RECT, -32'sh10000, -32'sd1, 0, 0, 0);
		send_beat(CMD_POLAR, 32'sh10000, 32'sh2D0000, 0, 0, 0);
		send_beat(CMD_POLAR, 32'sh10000, -32'sh5A0000, 0, 0, 0);
		send_beat(CMD_POLAR, -32'sh20000, 32'sh1E0000, 0, 0, 0);
		send_beat(CMD_POLAR, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0);
		send_beat(CMD_POLAR, 32'sh80000000, 32'sh80000000, 0, 0, 0);
		send_beat(CMD_POLAR, 32'sh10000, 32'sh3840000, 0, 0, 0);
		send_beat(CMD_ADD, 32'sh7FFFFFFF, 32'sh80000000, 1, -1, 0);
		send_beat(CMD_SUB, 32'sh80000000, 32'sh7FFFFFFF, 1, -1, 0);
		send_beat(CMD_NEG, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0);
		send_beat(CMD_SCALE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh7FFFFFFF);
		send_beat(CMD_SCALE, 32'sh18000, -32'sh8000, 0, 0, 32'sh8000);
		send_beat(3'd6, 32'sh10000, 32'sh10000, 0, 0, 0);
		send_beat(3'd7, -1, -1, -1, -1, -1);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				wait_drained();
			end
			c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			a = pick_value();
			b = pick_value();
			if (c == CMD_POLAR && $urandom_range(0, 1)) b = $signed($urandom_range(0, 720 << 16))
				- (32'sd360 <<< 16);
			send_beat(c, a, b, pick_value(), pick_value(), pick_value());
		end
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		$display("tb: %0d command beats sent, %0d results checked, all commands,",
			n_sent, board.checked);
		$display("tb: field extremes, wrap of angles and long output stalls covered");
		if (errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
